// File: hdl/tfp_pkg.sv
// Package for the typed frame parser with CRC-8 check.
// Holds frame markers, frame lengths, result kind codes and the CRC-8 byte fold.
// No dependencies.
package tfp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 11;
  localparam int unsigned IDX_W           = $clog2(MAX_FRAME_BYTES);

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam byte_t STATUS_SYNC0 = 8'hA5;
  localparam byte_t EVENT_LO     = 8'hB1;
  localparam byte_t EVENT_HI     = 8'hB6;
  localparam byte_t ACK_LO       = 8'hD1;
  localparam byte_t ACK_HI       = 8'hD6;
  localparam byte_t ACK_CMD_OFS  = 8'h10;
  localparam byte_t ACK_CMD_LO   = 8'hC1;
  localparam byte_t ACK_CMD_HI   = 8'hC6;
  localparam byte_t CRC_POLY     = 8'h07;

  localparam idx_t STATUS_LAST = idx_t'(11 - 1);
  localparam idx_t EVENT_LAST  = idx_t'(4 - 1);
  localparam idx_t ACK_LAST    = idx_t'(8 - 1);
  localparam idx_t IDX_FIRST   = idx_t'(0);
  localparam idx_t IDX_SECOND  = idx_t'(1);
  localparam idx_t IDX_MAX     = idx_t'(MAX_FRAME_BYTES);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_EVENT  = 2'd1;
  localparam kind_t KIND_ACK    = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  function automatic byte_t crc8_fold(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic is_event_start(input byte_t b);
    return (b >= EVENT_LO) && (b <= EVENT_HI);
  endfunction

  function automatic logic is_ack_start(input byte_t b);
    return (b >= ACK_LO) && (b <= ACK_HI);
  endfunction

endpackage

// File: hdl/typed_frame_parser_crc8.sv
// Typed frame parser: byte-wide input, one decoded record per good frame.
// Frame state, byte store, CRC-8 and the result register live here.
// Depends on tfp_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_rx_byte carries one link byte per
//   request. Result channel out_valid / out_stall / out_* carries one decoded
//   record per frame that passes its second-byte and CRC-8 checks.
//   Frames: status (A5 5A, 11 bytes), event (B1..B6, 4 bytes),
//   ack (D1..D6, 8 bytes); the last byte is the CRC-8 (poly 07, init 0).
//   Throughput: one byte per cycle while in_stall is low; frame state and running CRC update in
//   the cycle a byte is taken.
//   Output: the record appears on the outputs in the cycle after the last
//   byte of its frame is taken; it is held in the output register.
//   Stall: while a record waits under out_stall, non-final bytes are still
//   taken; in_stall rises only when the next byte could finish a frame.
//   Reset (rst_n low, synchronous): parser returns to hunting for a start
//   byte, CRC cleared, output register empty. Frame bytes are not cleared.
module typed_frame_parser_crc8
  import tfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic [7:0]  out_sequence_res,
  output logic        out_alive,
  output logic        out_shoot_enabled,
  output logic        out_power_on,
  output logic [15:0] out_health,
  output logic [15:0] out_heat_level,
  output logic [15:0] out_power_level,
  output logic [2:0]  out_event_code,
  output logic [7:0]  out_ack_command,
  output logic [31:0] out_ack_value,
  output logic [7:0]  out_ack_status
);

  byte_t store_r [MAX_FRAME_BYTES];
  idx_t  cnt_r, cnt_nxt;
  byte_t crc_r, crc_nxt;

  logic  out_valid_r, out_valid_nxt;
  kind_t kind_r;
  byte_t seq_r;
  logic  alive_r, shoot_r, pwr_on_r;
  logic [15:0] health_r, heat_r, power_r;
  logic [2:0]  evt_r;
  byte_t ack_cmd_r;
  logic [31:0] ack_val_r;
  byte_t ack_stat_r;

  byte_t first_b, swap_b, b;
  idx_t  last_idx, wr_idx;
  logic  wr_en, res_fire, accept, may_finish;
  kind_t kind_c;
  byte_t evt_diff;

  assign b       = in_rx_byte;
  assign first_b = store_r[0];
  assign swap_b  = {first_b[3:0], first_b[7:4]};

  always_comb begin
    if (first_b == STATUS_SYNC0) begin
      last_idx = STATUS_LAST;
      kind_c   = KIND_STATUS;
    end else if (is_event_start(first_b)) begin
      last_idx = EVENT_LAST;
      kind_c   = KIND_EVENT;
    end else begin
      last_idx = ACK_LAST;
      kind_c   = KIND_ACK;
    end
  end

  assign may_finish = (cnt_r > IDX_SECOND) && (cnt_r < IDX_MAX) && (cnt_r >= last_idx);
  assign in_stall   = out_valid_r && out_stall && may_finish;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    wr_en    = 1'b0;
    wr_idx   = cnt_r;
    res_fire = 1'b0;
    if (accept) begin
      if ((cnt_r == IDX_SECOND) && (b == swap_b)) begin
        wr_en   = 1'b1;
        wr_idx  = IDX_SECOND;
        crc_nxt = crc8_fold(crc_r, b);
        cnt_nxt = idx_t'(2);
      end else if (cnt_r <= IDX_SECOND) begin
        if ((b == STATUS_SYNC0) || is_event_start(b) || is_ack_start(b)) begin
          wr_en   = 1'b1;
          wr_idx  = IDX_FIRST;
          crc_nxt = crc8_fold(8'h00, b);
          cnt_nxt = IDX_SECOND;
        end else if (cnt_r == IDX_SECOND) begin
          cnt_nxt = IDX_FIRST;
          crc_nxt = 8'h00;
        end
      end else if (cnt_r >= IDX_MAX) begin
        cnt_nxt = IDX_FIRST;
        crc_nxt = 8'h00;
      end else if (cnt_r < last_idx) begin
        wr_en   = 1'b1;
        crc_nxt = crc8_fold(crc_r, b);
        cnt_nxt = cnt_r + idx_t'(1);
      end else begin
        wr_en    = 1'b1;
        cnt_nxt  = IDX_FIRST;
        crc_nxt  = 8'h00;
        res_fire = (crc_r == b);
      end
    end
  end

  assign evt_diff = first_b - EVENT_LO;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= IDX_FIRST;
      crc_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      kind_r     <= kind_c;
      seq_r      <= 8'h00;
      alive_r    <= 1'b0;
      shoot_r    <= 1'b0;
      pwr_on_r   <= 1'b0;
      health_r   <= 16'h0000;
      heat_r     <= 16'h0000;
      power_r    <= 16'h0000;
      evt_r      <= 3'd0;
      ack_cmd_r  <= 8'h00;
      ack_val_r  <= 32'h0000_0000;
      ack_stat_r <= 8'h00;
      case (kind_c)
        KIND_STATUS: begin
          seq_r    <= store_r[2];
          alive_r  <= store_r[3][0];
          shoot_r  <= store_r[3][1];
          pwr_on_r <= store_r[3][2];
          health_r <= {store_r[5], store_r[4]};
          heat_r   <= {store_r[7], store_r[6]};
          power_r  <= {store_r[9], store_r[8]};
        end
        KIND_EVENT: begin
          seq_r <= store_r[2];
          evt_r <= evt_diff[2:0];
        end
        KIND_ACK: begin
          ack_cmd_r  <= first_b - ACK_CMD_OFS;
          ack_val_r  <= {store_r[5], store_r[4], store_r[3], store_r[2]};
          ack_stat_r <= store_r[6];
        end
        default: begin
          kind_r <= KIND_NONE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_kind    = kind_r;
  assign out_sequence_res  = seq_r;
  assign out_alive         = alive_r;
  assign out_shoot_enabled = shoot_r;
  assign out_power_on      = pwr_on_r;
  assign out_health        = health_r;
  assign out_heat_level    = heat_r;
  assign out_power_level   = power_r;
  assign out_event_code    = evt_r;
  assign out_ack_command   = ack_cmd_r;
  assign out_ack_value     = ack_val_r;
  assign out_ack_status    = ack_stat_r;

endmodule

// File: hdl/tfp_checker.sv
// Port-level checker for typed_frame_parser_crc8, attached with bind.
// Watches reset behavior, result hold under stall and per-kind field rules.
// Depends on tfp_pkg.
module tfp_checker
  import tfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_frame_kind,
  input logic [7:0]  out_sequence_res,
  input logic [15:0] out_health,
  input logic [2:0]  out_event_code,
  input logic [7:0]  out_ack_command,
  input logic [31:0] out_ack_value
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_kind)
      && $stable(out_sequence_res) && $stable(out_ack_value) && $stable(out_health))
    else $error("stalled request changed or dropped");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_kind == KIND_STATUS) || (out_frame_kind == KIND_EVENT)
      || (out_frame_kind == KIND_ACK))
    else $error("bad frame kind");

  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_kind == KIND_EVENT) |->
      (out_event_code <= 3'd5) && (out_health == 16'h0000) && (out_ack_value == 32'h0))
    else $error("event record fields wrong");

  a_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_kind == KIND_ACK) |->
      (out_ack_command >= ACK_CMD_LO) && (out_ack_command <= ACK_CMD_HI)
      && (out_sequence_res == 8'h00) && (out_event_code == 3'd0))
    else $error("ack record fields wrong");

endmodule

bind typed_frame_parser_crc8 tfp_checker u_tfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_kind   (out_frame_kind),
  .out_sequence_res (out_sequence_res),
  .out_health       (out_health),
  .out_event_code   (out_event_code),
  .out_ack_command  (out_ack_command),
  .out_ack_value    (out_ack_value)
);
